/* hw/rtl/gcfs_pkg.sv */
// Gauge channel filter/scaler package: field widths, channel codes, scale constants
// and the status struct of the serial divider.
// No dependencies.
package gcfs_pkg;

  localparam int NUM_CH         = 4;
  localparam int CH_W           = 2;
  localparam int SAMPLE_W       = 10;
  localparam int LIMIT_W        = 8;
  localparam int READING_W      = 15;
  localparam int PROD_W         = 24;
  localparam int QUO_W          = 14;
  localparam int FULL_SCALE     = 1023;
  localparam int MED_N          = 3;
  localparam int AVG_WINDOW_DEF = 8;
  localparam int K_PCT          = 100;
  localparam int K_COOL         = 170;
  localparam int K_MV           = 16000;
  localparam int COOL_OFFSET    = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd10;

  typedef enum logic [CH_W-1:0] {
    CH_FUEL    = 2'd0,
    CH_COOLANT = 2'd1,
    CH_BATTERY = 2'd2,
    CH_OIL     = 2'd3
  } chan_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

/* hw/rtl/gcfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gcfs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/gcfs_div.sv */
// Restoring serial divider, one quotient bit per cycle.
// Depends on gcfs_pkg for the status struct.
module gcfs_div import gcfs_pkg::*; #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output div_status_t           status
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVISOR_W-1:0]  dsr_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_diff;
  logic                  ge;
  logic [DIVISOR_W-1:0]  rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, quo_r[DIVIDEND_W-1]};
    rem_diff = rem_sh - {1'b0, dsr_r};
    ge       = rem_sh >= {1'b0, dsr_r};
    rem_nxt  = ge ? rem_diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= dividend;
        rem_r <= '0;
        dsr_r <= divisor;
        cnt_r <= CNT_W'(DIVIDEND_W);
      end else if (cnt_r != '0) begin
        quo_r  <= {quo_r[DIVIDEND_W-2:0], ge};
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == CNT_W'(1));
      end
    end
  end

  assign quotient    = quo_r;
  assign status.busy = (cnt_r != '0);
  assign status.done = done_r;

endmodule

/* hw/rtl/gauge_channel_filter_scaler_unit.sv */
// Sequence: averaging channels pass S_WRITE, S_SUM (summing the window, n = samples in it, into
//   SUM_W bits, 13 at a window of 8), S_DIVGO, S_DIVW, S_MUL, S_SC1, S_SC2; median channels
//   pass S_MRD0, S_MRD1, S_MWR2, S_MWR1, S_MWR0, S_MUL, S_SC1, S_SC2. One request at a time, the
//   next taken the cycle after the result is loaded; S_SC2 holds while the output is stalled.
// Reset (synchronous, rst_n low): counters, positions and bad-run counts clear, all channels
//   valid, limit 10. The sample RAM is not cleared; only written entries are used.
module gauge_channel_filter_scaler_unit import gcfs_pkg::*; #(
  parameter int AVG_WINDOW = AVG_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CH_W-1:0]             in_channel,
  input  logic [SAMPLE_W-1:0]         in_raw_sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [CH_W-1:0]             out_channel_out,
  output logic [SAMPLE_W-1:0]         out_filtered_value,
  output logic                        out_channel_valid,
  output logic signed [READING_W-1:0] out_reading,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [LIMIT_W-1:0]          cfg_invalid_limit
);

  localparam int SLOT_W = $clog2(AVG_WINDOW);
  localparam int CNT_W  = $clog2(AVG_WINDOW + 1);
  localparam int SUM_W  = $clog2(AVG_WINDOW * FULL_SCALE + 1);
  localparam int ADDR_W = CH_W + SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SUM, S_DIVGO, S_DIVW,
    S_MRD0, S_MRD1, S_MWR2, S_MWR1, S_MWR0,
    S_MUL, S_SC1, S_SC2
  } state_t;

  state_t               state_r, state_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic [SLOT_W-1:0]    pos_r     [NUM_CH];
  logic [CNT_W-1:0]     seen_r    [NUM_CH];
  logic [LIMIT_W-1:0]   bad_cnt_r [NUM_CH];
  logic [NUM_CH-1:0]    valid_r;
  logic [CH_W-1:0]      ch_r;
  logic [SAMPLE_W-1:0]  raw_r;
  logic [CNT_W-1:0]     n_r;
  logic [CNT_W-1:0]     k_r;
  logic [SUM_W-1:0]     sum_r;
  logic [SAMPLE_W-1:0]  m0_r, m1_r;
  logic [SAMPLE_W-1:0]  filt_r;
  logic [PROD_W-1:0]    prod_r;
  logic [QUO_W-1:0]     a_r;
  logic [QUO_W:0]       s1_r;
  logic                 out_valid_r;
  logic [CH_W-1:0]      out_ch_r;
  logic [SAMPLE_W-1:0]  out_filt_r;
  logic                 out_cv_r;
  logic [READING_W-1:0] out_rd_r;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0]  ram_wdata, ram_rdata;
  logic [SUM_W-1:0]     div_quo;
  div_status_t          div_st;
  logic                 out_free;
  logic                 in_bad;
  logic [CNT_W-1:0]     seen_inc;
  logic [SAMPLE_W-1:0]  med_val;
  logic [PROD_W-1:0]    k_sel;
  logic [10:0]          s2;
  logic [QUO_W-1:0]     q;
  logic [READING_W-1:0] rd_val;

  function automatic logic [SAMPLE_W-1:0] mid3(input logic [SAMPLE_W-1:0] a,
                                              input logic [SAMPLE_W-1:0] b,
                                              input logic [SAMPLE_W-1:0] c);
    logic [SAMPLE_W-1:0] lo, hi;
    lo = (a > b) ? b : a;
    hi = (a > b) ? a : b;
    if (hi > c) hi = c;
    if (lo > hi) hi = lo;
    return hi;
  endfunction

  gcfs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_CH << SLOT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  gcfs_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_DIVGO),
    .dividend (sum_r),
    .divisor  (n_r),
    .quotient (div_quo),
    .status   (div_st)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_bad    = (in_raw_sample == '0) || (in_raw_sample == SAMPLE_W'(FULL_SCALE));
  assign seen_inc  = (seen_r[ch_r] < CNT_W'(AVG_WINDOW)) ? seen_r[ch_r] + 1'b1 : seen_r[ch_r];
  assign med_val   = mid3(raw_r, m0_r, m1_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {ch_r, pos_r[ch_r]};
    ram_wdata = raw_r;
    ram_raddr = {ch_r, k_r[SLOT_W-1:0]};
    unique case (state_r)
      S_WRITE: ram_we = 1'b1;
      S_MRD0:  ram_raddr = {ch_r, SLOT_W'(0)};
      S_MRD1:  ram_raddr = {ch_r, SLOT_W'(1)};
      S_MWR2: begin
        ram_we    = 1'b1;
        ram_waddr = {ch_r, SLOT_W'(2)};
        ram_wdata = ram_rdata;
      end
      S_MWR1: begin
        ram_we    = 1'b1;
        ram_waddr = {ch_r, SLOT_W'(1)};
        ram_wdata = m0_r;
      end
      S_MWR0: begin
        ram_we    = 1'b1;
        ram_waddr = {ch_r, SLOT_W'(0)};
      end
      default: ;
    endcase
  end

  always_comb begin
    unique case (chan_t'(ch_r))
      CH_COOLANT: k_sel = PROD_W'(K_COOL);
      CH_BATTERY: k_sel = PROD_W'(K_MV);
      default:    k_sel = PROD_W'(K_PCT);
    endcase
  end

  // divide by 1023 as a + (a + b) / 1023 with x = 1024a + b
  always_comb begin
    s2 = {6'b0, s1_r[QUO_W:10]} + {1'b0, s1_r[9:0]};
    q  = a_r + QUO_W'(s1_r[QUO_W:10]) + QUO_W'(s2 >= 11'(FULL_SCALE));
    unique case (chan_t'(ch_r))
      CH_COOLANT: rd_val = READING_W'(q) - READING_W'(COOL_OFFSET);
      CH_BATTERY: rd_val = (q > QUO_W'(K_MV)) ? READING_W'(K_MV) : READING_W'(q);
      default:    rd_val = (q > QUO_W'(K_PCT)) ? READING_W'(K_PCT) : READING_W'(q);
    endcase
    if (!valid_r[ch_r]) rd_val = '0;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_channel[1] == 1'b0) ? S_WRITE : S_MRD0;
        end
      end
      S_WRITE: state_nxt = S_SUM;
      S_SUM:   if (k_r == n_r) state_nxt = S_DIVGO;
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW:  if (div_st.done) state_nxt = S_MUL;
      S_MRD0:  state_nxt = S_MRD1;
      S_MRD1:  state_nxt = S_MWR2;
      S_MWR2:  state_nxt = S_MWR1;
      S_MWR1:  state_nxt = S_MWR0;
      S_MWR0:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_SC1;
      S_SC1:   state_nxt = S_SC2;
      S_SC2:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= LIMIT_RST;
      valid_r     <= '1;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        pos_r[i]     <= '0;
        seen_r[i]    <= '0;
        bad_cnt_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_invalid_limit;
      end
      if (state_r == S_SC2 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            ch_r  <= in_channel;
            raw_r <= in_raw_sample;
            if (in_bad) begin
              if (bad_cnt_r[in_channel] < limit_r) begin
                bad_cnt_r[in_channel] <= bad_cnt_r[in_channel] + 1'b1;
              end else begin
                valid_r[in_channel] <= 1'b0;
              end
            end else begin
              bad_cnt_r[in_channel] <= '0;
              valid_r[in_channel]   <= 1'b1;
            end
          end
        end
        S_WRITE: begin
          pos_r[ch_r]  <= (pos_r[ch_r] == SLOT_W'(AVG_WINDOW - 1)) ? '0 : pos_r[ch_r] + 1'b1;
          seen_r[ch_r] <= seen_inc;
          n_r          <= seen_inc;
          k_r          <= '0;
          sum_r        <= '0;
        end
        S_SUM: begin
          if (k_r != '0) begin
            sum_r <= sum_r + SUM_W'(ram_rdata);
          end
          if (k_r != n_r) begin
            k_r <= k_r + 1'b1;
          end
        end
        S_DIVW: begin
          if (div_st.done) begin
            filt_r <= div_quo[SAMPLE_W-1:0];
          end
        end
        S_MRD1: m0_r <= ram_rdata;
        S_MWR2: m1_r <= ram_rdata;
        S_MWR0: begin
          if (seen_r[ch_r] < CNT_W'(MED_N)) begin
            seen_r[ch_r] <= seen_r[ch_r] + 1'b1;
            filt_r       <= raw_r;
          end else begin
            filt_r <= med_val;
          end
        end
        S_MUL: prod_r <= PROD_W'(filt_r) * k_sel;
        S_SC1: begin
          a_r  <= prod_r[PROD_W-1:10];
          s1_r <= {1'b0, prod_r[PROD_W-1:10]} + (QUO_W+1)'(prod_r[9:0]);
        end
        S_SC2: begin
          if (out_free) begin
            out_ch_r    <= ch_r;
            out_filt_r  <= filt_r;
            out_cv_r    <= valid_r[ch_r];
            out_rd_r    <= rd_val;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel_out    = out_ch_r;
  assign out_filtered_value = out_filt_r;
  assign out_channel_valid  = out_cv_r;
  assign out_reading        = out_rd_r;

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_st.busy)
    else $error("divider busy while idle");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_channel_valid) |-> (out_reading == '0))
    else $error("reading not zero on invalid channel");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("request accepted but sequencer stayed idle");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |-> (n_r != '0 && n_r <= CNT_W'(AVG_WINDOW) && k_r <= n_r))
    else $error("window count out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC2 && out_valid && out_stall) |=> (state_r == S_SC2))
    else $error("result dropped while output held");

endmodule

/* tb/tb_gauge_channel_filter_scaler_unit.sv */
// Testbench for gauge_channel_filter_scaler_unit: a directed set of gauge samples, then random
// traffic under several fault limits, each result checked against an in-bench predictor.
// Depends on gcfs_pkg and the unit's RTL.
module tb_gauge_channel_filter_scaler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gcfs_pkg::*;

  typedef struct {
    chan_t                ch;
    logic [SAMPLE_W-1:0]  raw;
  } gauge_sample_t;

  typedef struct {
    chan_t                       ch;
    logic [SAMPLE_W-1:0]         filtered;
    logic                        ok;
    logic signed [READING_W-1:0] reading;
  } gauge_result_t;

  localparam int HOLDOFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 40;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CH_W-1:0]             in_channel = '0;
  logic [SAMPLE_W-1:0]         in_raw_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [CH_W-1:0]             out_channel_out;
  logic [SAMPLE_W-1:0]         out_filtered_value;
  logic                        out_channel_valid;
  logic signed [READING_W-1:0] out_reading;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [LIMIT_W-1:0]          cfg_invalid_limit = '0;

  gauge_sample_t sample_queue[$];
  gauge_result_t pending_readings[$];
  gauge_sample_t next_sample;
  gauge_result_t got_reading;
  gauge_result_t want_reading;

  logic [SAMPLE_W-1:0] win_store [NUM_CH][AVG_WINDOW_DEF];
  logic [2:0]          win_pos   [NUM_CH];
  logic [3:0]          win_count [NUM_CH];
  logic [LIMIT_W-1:0]  fault_run [NUM_CH];
  logic                chan_ok   [NUM_CH];
  logic [LIMIT_W-1:0]  fault_limit;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 55;
  int unsigned holdoff_reqs = 0;
  int unsigned holdoff_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;

  gauge_channel_filter_scaler_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_channel         (in_channel),
    .in_raw_sample      (in_raw_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_channel_out    (out_channel_out),
    .out_filtered_value (out_filtered_value),
    .out_channel_valid  (out_channel_valid),
    .out_reading        (out_reading),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_invalid_limit  (cfg_invalid_limit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic gauge_result_t predict_gauge_result(chan_t ch, logic [SAMPLE_W-1:0] raw);
    gauge_result_t r;
    int unsigned   total;
    int unsigned   q;
    int            rd;
    logic [SAMPLE_W-1:0] a, b, c;
    total = 0;
    rd = 0;
    r.ch = ch;
    if (ch == CH_FUEL || ch == CH_COOLANT) begin
      win_store[ch][win_pos[ch]] = raw;
      win_pos[ch] = (win_pos[ch] == AVG_WINDOW_DEF - 1) ? 3'd0 : win_pos[ch] + 3'd1;
      if (win_count[ch] < AVG_WINDOW_DEF) win_count[ch] = win_count[ch] + 4'd1;
      for (int k = 0; k < win_count[ch]; k++) total += win_store[ch][k];
      r.filtered = SAMPLE_W'(total / win_count[ch]);
    end else begin
      win_store[ch][2] = win_store[ch][1];
      win_store[ch][1] = win_store[ch][0];
      win_store[ch][0] = raw;
      if (win_count[ch] < MED_N) begin
        win_count[ch] = win_count[ch] + 4'd1;
        r.filtered = raw;
      end else begin
        a = win_store[ch][0];
        b = win_store[ch][1];
        c = win_store[ch][2];
        if (a > b) r.filtered = (b > c) ? b : ((a > c) ? c : a);
        else       r.filtered = (a > c) ? a : ((b > c) ? c : b);
      end
    end
    if (raw == '0 || raw == FULL_SCALE) begin
      if (fault_run[ch] < fault_limit) fault_run[ch] = fault_run[ch] + 8'd1;
      else chan_ok[ch] = 1'b0;
    end else begin
      fault_run[ch] = '0;
      chan_ok[ch] = 1'b1;
    end
    r.ok = chan_ok[ch];
    if (chan_ok[ch]) begin
      case (ch)
        CH_FUEL, CH_OIL: begin
          q = r.filtered * K_PCT / FULL_SCALE;
          rd = (q > K_PCT) ? K_PCT : int'(q);
        end
        CH_COOLANT: begin
          q = r.filtered * K_COOL / FULL_SCALE;
          rd = int'(q) - COOL_OFFSET;
        end
        default: begin
          q = r.filtered * K_MV / FULL_SCALE;
          rd = (q > K_MV) ? K_MV : int'(q);
        end
      endcase
    end
    r.reading = READING_W'(rd);
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] good_raw();
    case ($urandom_range(0, 9))
      0:       return 10'd1;
      1:       return 10'd1022;
      default: return SAMPLE_W'($urandom_range(1, FULL_SCALE - 1));
    endcase
  endfunction

  function automatic logic [SAMPLE_W-1:0] bad_raw();
    return $urandom_range(0, 1) ? SAMPLE_W'(FULL_SCALE) : '0;
  endfunction

  // Sender: advance on acceptance, hold the request while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        pending_readings.push_back(predict_gauge_result(chan_t'(in_channel), in_raw_sample));
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_sample = sample_queue.pop_front();
          in_valid <= 1'b1;
          in_channel <= next_sample.ch;
          in_raw_sample <= next_sample.raw;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (holdoff_reqs != holdoff_served) begin
        holdoff_served = holdoff_reqs;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_reading.ch = chan_t'(out_channel_out);
      got_reading.filtered = out_filtered_value;
      got_reading.ok = out_channel_valid;
      got_reading.reading = out_reading;
      if (pending_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ch %0d f %0d ok %0b rd %0d", got_reading.ch,
                   got_reading.filtered, got_reading.ok, got_reading.reading);
      end else begin
        want_reading = pending_readings.pop_front();
        if (got_reading.ch !== want_reading.ch || got_reading.filtered !== want_reading.filtered ||
            got_reading.ok !== want_reading.ok || got_reading.reading !== want_reading.reading) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected ch %0d f %0d ok %0b rd %0d, got ch %0d f %0d ok %0b rd %0d",
                     want_reading.ch, want_reading.filtered, want_reading.ok,
                     want_reading.reading, got_reading.ch, got_reading.filtered,
                     got_reading.ok, got_reading.reading);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_sample(chan_t ch, logic [SAMPLE_W-1:0] raw);
    gauge_sample_t s;
    s.ch = ch;
    s.raw = raw;
    sample_queue.push_back(s);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || pending_readings.size() != 0);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] limit);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_invalid_limit <= limit;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    fault_limit = limit;
  endtask

  task automatic queue_traffic(int unsigned n);
    int unsigned added;
    int unsigned len;
    int unsigned kind;
    chan_t       ch;
    added = 0;
    while (added < n) begin
      ch = chan_t'($urandom_range(0, NUM_CH - 1));
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        len = $urandom_range(1, 12);
        repeat (len) push_sample(ch, good_raw());
      end else if (kind < 75) begin
        if (fault_limit > 20 && $urandom_range(0, 3) != 0)
          len = $urandom_range(0, 20);
        else
          len = fault_limit + $urandom_range(0, 3);
        repeat (len) push_sample(ch, bad_raw());
        push_sample(ch, good_raw());
        len++;
      end else if (kind < 90) begin
        len = $urandom_range(4, 10);
        repeat (len)
          push_sample(chan_t'($urandom_range(0, NUM_CH - 1)),
                      $urandom_range(0, 3) == 0 ? bad_raw() : good_raw());
      end else begin
        len = 1;
        push_sample(ch, SAMPLE_W'($urandom_range(0, FULL_SCALE)));
      end
      added += len;
    end
  endtask

  initial begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int k = 0; k < AVG_WINDOW_DEF; k++) win_store[c][k] = '0;
      win_pos[c] = '0;
      win_count[c] = '0;
      fault_run[c] = '0;
      chan_ok[c] = 1'b1;
    end
    fault_limit = LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    push_sample(CH_FUEL, 10'd1022);
    push_sample(CH_FUEL, 10'd1);
    push_sample(CH_FUEL, 10'h155);
    push_sample(CH_COOLANT, 10'h2AA);
    push_sample(CH_COOLANT, 10'd1022);
    push_sample(CH_BATTERY, 10'd1022);
    push_sample(CH_BATTERY, 10'd1);
    push_sample(CH_BATTERY, 10'd500);
    push_sample(CH_BATTERY, 10'd700);
    push_sample(CH_OIL, 10'd1022);
    push_sample(CH_OIL, 10'd1023);
    push_sample(CH_OIL, 10'd0);
    push_sample(CH_OIL, 10'd512);
    wait_drained();
    write_limit(8'd0);
    push_sample(CH_BATTERY, 10'd0);
    push_sample(CH_BATTERY, 10'd1023);
    push_sample(CH_BATTERY, 10'd600);
    push_sample(CH_OIL, 10'd1023);
    push_sample(CH_FUEL, 10'd0);
    push_sample(CH_COOLANT, 10'd1023);
    push_sample(CH_COOLANT, 10'd0);
    wait_drained();

    write_limit(8'd255);
    queue_traffic(300);
    wait_drained();
    write_limit(8'd3);
    queue_traffic(250);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 33;
    write_limit(8'd1);
    queue_traffic(120);
    holdoff_reqs++;
    queue_traffic(130);
    wait_drained();
    write_limit(LIMIT_RST);
    queue_traffic(120);
    wait_drained();
    queue_traffic(130);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(8'd0);
    queue_traffic(250);
    wait_drained();
    write_limit(LIMIT_W'($urandom_range(2, 254)));
    queue_traffic(250);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0 && pending_readings.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
